>>> rtl/msfc_pkg.sv
// shared types, codes and helpers for the search compare filter
package msfc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned SUM_LAT = 5;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE = 8'd3;

  typedef enum logic [2:0] {
    CMP_EQ  = 3'd0,
    CMP_GT  = 3'd1,
    CMP_LT  = 3'd2,
    CMP_NE  = 3'd3,
    CMP_INC = 3'd4,
    CMP_DEC = 3'd5
  } cmp_mode_e;

  typedef enum logic [1:0] {
    V_KEEP    = 2'd0,
    V_REJECT  = 2'd1,
    V_INVALID = 2'd2
  } verdict_e;

  typedef struct packed {
    cmp_mode_e mode;
    logic      fmode;
    logic      useval;
  } cfg_t;

  // unpacked single: value = 1.man[22:0] * 2^exp when finite and nonzero
  typedef struct packed {
    logic              sgn;
    logic              zero;
    logic              inf;
    logic              nan;
    logic signed [9:0] exp;
    logic [23:0]       man;
  } uf_t;

  // rounded sum, msb of man at bit 52 weighs 2^exp
  typedef struct packed {
    logic               sgn;
    logic               zero;
    logic               inf;
    logic               nan;
    logic signed [10:0] exp;
    logic [52:0]        man;
  } res_t;

  typedef struct packed {
    verdict_e pre;
    logic     need;
    uf_t      t;
  } dec_t;

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic verdict_e keep(input logic c);
    return c ? V_KEEP : V_REJECT;
  endfunction

endpackage

>>> rtl/msfc_front.sv
// input stage: operand masking, wrapped integer sums, float unpacking
module msfc_front #(
  parameter int unsigned VALUE_BITS = msfc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [63:0]           value_i,
  input  logic [63:0]           prev_i,
  input  logic [63:0]           cur_i,
  output logic [VALUE_BITS-1:0] p_o,
  output logic [VALUE_BITS-1:0] c_o,
  output logic [VALUE_BITS-1:0] v_o,
  output logic [VALUE_BITS-1:0] pv_o,
  output logic [VALUE_BITS-1:0] cv_o,
  output msfc_pkg::uf_t         fp_o,
  output msfc_pkg::uf_t         fc_o,
  output msfc_pkg::uf_t         fv_o,
  output logic [31:0]           fpb_o,
  output logic [31:0]           fcb_o,
  output logic [31:0]           fvb_o
);
  import msfc_pkg::*;

  function automatic uf_t unpack(input logic [31:0] b);
    uf_t        u;
    logic [6:0] lz;
    u     = '0;
    u.sgn = b[31];
    lz    = lzc64({1'b0, b[22:0], 40'd0});
    if (b[30:23] == 8'hff) begin
      u.inf = (b[22:0] == 23'd0);
      u.nan = (b[22:0] != 23'd0);
    end else if (b[30:23] == 8'h00) begin
      if (b[22:0] == 23'd0) begin
        u.zero = 1'b1;
      end else begin
        u.man = {1'b0, b[22:0]} << lz[4:0];
        u.exp = -10'sd126 - $signed({5'd0, lz[4:0]});
      end
    end else begin
      u.man = {1'b1, b[22:0]};
      u.exp = $signed({2'd0, b[30:23]}) - 10'sd127;
    end
    return u;
  endfunction

  logic [VALUE_BITS-1:0] p, c, v;
  logic [VALUE_BITS-1:0] p_q, c_q, v_q, pv_q, cv_q;
  uf_t                   fp_q, fc_q, fv_q;
  logic [31:0]           fpb_q, fcb_q, fvb_q;

  assign p = prev_i[VALUE_BITS-1:0];
  assign c = cur_i[VALUE_BITS-1:0];
  assign v = value_i[VALUE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p;
      c_q   <= c;
      v_q   <= v;
      pv_q  <= p + v;
      cv_q  <= c + v;
      fp_q  <= unpack(prev_i[31:0]);
      fc_q  <= unpack(cur_i[31:0]);
      fv_q  <= unpack(value_i[31:0]);
      fpb_q <= prev_i[31:0];
      fcb_q <= cur_i[31:0];
      fvb_q <= value_i[31:0];
    end
  end

  assign p_o   = p_q;
  assign c_o   = c_q;
  assign v_o   = v_q;
  assign pv_o  = pv_q;
  assign cv_o  = cv_q;
  assign fp_o  = fp_q;
  assign fc_o  = fc_q;
  assign fv_o  = fv_q;
  assign fpb_o = fpb_q;
  assign fcb_o = fcb_q;
  assign fvb_o = fvb_q;

endmodule

>>> rtl/msfc_decide.sv
// decision stage: compares, floors, conversions and adder operand select
module msfc_decide #(
  parameter int unsigned VALUE_BITS = msfc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  msfc_pkg::cfg_t        cfg_i,
  input  logic [VALUE_BITS-1:0] p_i,
  input  logic [VALUE_BITS-1:0] c_i,
  input  logic [VALUE_BITS-1:0] v_i,
  input  logic [VALUE_BITS-1:0] pv_i,
  input  logic [VALUE_BITS-1:0] cv_i,
  input  msfc_pkg::uf_t         fp_i,
  input  msfc_pkg::uf_t         fc_i,
  input  msfc_pkg::uf_t         fv_i,
  input  logic [31:0]           fpb_i,
  input  logic [31:0]           fcb_i,
  input  logic [31:0]           fvb_i,
  output msfc_pkg::uf_t         x_o,
  output msfc_pkg::uf_t         y_o,
  output logic                  single_o,
  output msfc_pkg::dec_t        dec_o
);
  import msfc_pkg::*;

  function automatic uf_t floor_uf(input uf_t x);
    uf_t         r;
    logic [4:0]  sh;
    logic [23:0] mask, masked;
    logic [24:0] bump;
    r      = x;
    sh     = 5'(5'd23 - x.exp[4:0]);
    mask   = 24'((25'd1 << sh) - 25'd1);
    masked = x.man & ~mask;
    bump   = {1'b0, masked} + (25'd1 << sh);
    if (!x.zero && !x.inf && !x.nan && x.exp < 10'sd23) begin
      if (x.exp < 10'sd0) begin
        r.exp = 10'sd0;
        if (x.sgn) begin
          r.man = 24'h800000;
        end else begin
          r.zero = 1'b1;
          r.man  = 24'd0;
        end
      end else if (x.sgn && ((x.man & mask) != 24'd0)) begin
        if (bump[24]) begin
          r.man = 24'h800000;
          r.exp = x.exp + 10'sd1;
        end else begin
          r.man = bump[23:0];
        end
      end else begin
        r.man = masked;
      end
    end
    return r;
  endfunction

  function automatic logic is_frac(input uf_t x);
    logic [4:0]  sh;
    logic [23:0] mask;
    logic        f;
    sh   = 5'(5'd23 - x.exp[4:0]);
    mask = 24'((25'd1 << sh) - 25'd1);
    if (x.nan) f = 1'b1;
    else if (x.inf || x.zero || x.exp >= 10'sd23) f = 1'b0;
    else if (x.exp < 10'sd0) f = 1'b1;
    else f = ((x.man & mask) != 24'd0);
    return f;
  endfunction

  function automatic logic uf_eq(input uf_t a, input uf_t b);
    logic e;
    if (a.nan || b.nan) e = 1'b0;
    else if (a.zero || b.zero) e = a.zero && b.zero;
    else if (a.inf || b.inf) e = a.inf && b.inf && (a.sgn == b.sgn);
    else e = (a.sgn == b.sgn) && (a.exp == b.exp) && (a.man == b.man);
    return e;
  endfunction

  function automatic logic [31:0] to_u32(input logic [31:0] b);
    logic [31:0] r;
    logic [7:0]  e;
    logic [3:0]  shl;
    logic [4:0]  shr;
    e   = b[30:23];
    shl = 4'(e - 8'd150);
    shr = 5'(8'd150 - e);
    if (b[31] || b[30:0] == 31'd0 || (e == 8'hff && b[22:0] != 23'd0)) r = 32'd0;
    else if (e >= 8'd159) r = 32'hffff_ffff;
    else if (e < 8'd127) r = 32'd0;
    else if (e >= 8'd150) r = {8'd0, 1'b1, b[22:0]} << shl;
    else r = {8'd0, 1'b1, b[22:0]} >> shr;
    return r;
  endfunction

  function automatic logic [31:0] fkey(input logic [31:0] b);
    logic [31:0] k;
    if (b[30:0] == 31'd0) k = 32'h8000_0000;
    else if (b[31]) k = ~b;
    else k = {1'b1, b[30:0]};
    return k;
  endfunction

  function automatic verdict_e order_v(input cmp_mode_e m, input logic eq, input logic lt,
                                       input logic gt);
    verdict_e r;
    case (m)
      CMP_EQ:          r = keep(eq);
      CMP_GT, CMP_INC: r = keep(lt);
      CMP_LT, CMP_DEC: r = keep(gt);
      CMP_NE:          r = keep(!eq);
      default:         r = V_INVALID;
    endcase
    return r;
  endfunction

  uf_t         flp, flc, x_d, t_d;
  uf_t         x_q, y_q;
  logic        frac, ord, keq, klt, kgt, need_d, single_q;
  logic [31:0] up, uc, kc, kv;
  verdict_e    pre_d;
  dec_t        dec_q;

  always_comb begin
    flp  = floor_uf(fp_i);
    flc  = floor_uf(fc_i);
    frac = is_frac(fv_i);
    up   = to_u32(fpb_i);
    uc   = to_u32(fcb_i);
    kc   = fkey(fcb_i);
    kv   = fkey(fvb_i);
    ord  = !fc_i.nan && !fv_i.nan;
    keq  = ord && (kc == kv);
    klt  = ord && (kc < kv);
    kgt  = ord && (kc > kv);

    need_d = 1'b0;
    x_d    = frac ? fc_i : flc;
    t_d    = frac ? fp_i : flp;
    if (cfg_i.mode == CMP_INC) begin
      x_d = frac ? fp_i : flp;
      t_d = frac ? fc_i : flc;
    end

    if (cfg_i.fmode) begin
      if (cfg_i.useval) begin
        if (fc_i.nan) begin
          pre_d = V_INVALID;
        end else begin
          case (cfg_i.mode)
            CMP_EQ:  pre_d = frac ? keep(keq) : keep(uf_eq(flc, fv_i));
            CMP_GT:  pre_d = keep(kgt);
            CMP_LT:  pre_d = keep(klt);
            CMP_NE:  pre_d = keep(!keq);
            CMP_INC, CMP_DEC: begin
              pre_d  = V_REJECT;
              need_d = 1'b1;
            end
            default: pre_d = V_INVALID;
          endcase
        end
      end else begin
        pre_d = order_v(cfg_i.mode, up == uc, up < uc, up > uc);
      end
    end else if (cfg_i.useval) begin
      case (cfg_i.mode)
        CMP_EQ:  pre_d = keep(c_i == v_i);
        CMP_GT:  pre_d = keep(c_i > v_i);
        CMP_LT:  pre_d = keep(c_i < v_i);
        CMP_NE:  pre_d = keep(c_i != v_i);
        CMP_INC: pre_d = keep(c_i == pv_i);
        CMP_DEC: pre_d = keep(cv_i == p_i);
        default: pre_d = V_INVALID;
      endcase
    end else begin
      pre_d = order_v(cfg_i.mode, p_i == c_i, p_i < c_i, p_i > c_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q        <= x_d;
      y_q        <= fv_i;
      single_q   <= frac;
      dec_q.pre  <= pre_d;
      dec_q.need <= need_d;
      dec_q.t    <= t_d;
    end
  end

  assign x_o      = x_q;
  assign y_o      = y_q;
  assign single_o = single_q;
  assign dec_o    = dec_q;

endmodule

>>> rtl/msfc_sum.sv
// pipelined float adder: align, add, count, normalize with double rounding, single rounding
module msfc_sum (
  input  logic           clk_i,
  input  logic           en_i,
  input  msfc_pkg::uf_t  a_i,
  input  msfc_pkg::uf_t  b_i,
  input  logic           single_i,
  output msfc_pkg::res_t res_o
);
  import msfc_pkg::*;

  typedef struct packed {
    logic               sgn;
    logic signed [10:0] exp;
    logic               nan;
    logic               inf;
    logic               isg;
    logic               single;
  } tag_t;

  // align
  logic signed [10:0] ea, eb, ebig, esml, exp_gap;
  logic               a_big;
  logic [23:0]        mbig, msml;
  logic [5:0]         dcl;
  logic [57:0]        ext, shf, lost;
  tag_t               tag_d;
  logic [58:0]        big1_q, sml1_q;
  logic               sub1_q;
  tag_t               tag1_q;

  always_comb begin
    ea      = a_i.zero ? -11'sd512 : $signed({a_i.exp[9], a_i.exp});
    eb      = b_i.zero ? -11'sd512 : $signed({b_i.exp[9], b_i.exp});
    a_big   = (ea > eb) || ((ea == eb) && (a_i.man >= b_i.man));
    ebig    = a_big ? ea : eb;
    esml    = a_big ? eb : ea;
    mbig    = a_big ? a_i.man : b_i.man;
    msml    = a_big ? b_i.man : a_i.man;
    exp_gap = ebig - esml;
    dcl     = (exp_gap > 11'sd58) ? 6'd59 : 6'(exp_gap);
    ext     = {msml, 34'd0};
    shf     = ext >> dcl;
    lost    = ext & 58'((64'd1 << dcl) - 64'd1);
    tag_d.sgn    = a_big ? a_i.sgn : b_i.sgn;
    tag_d.exp    = ebig;
    tag_d.nan    = a_i.nan || b_i.nan || (a_i.inf && b_i.inf && (a_i.sgn != b_i.sgn));
    tag_d.inf    = a_i.inf || b_i.inf;
    tag_d.isg    = a_i.inf ? a_i.sgn : b_i.sgn;
    tag_d.single = single_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big1_q <= {1'b0, mbig, 34'd0};
      sml1_q <= {1'b0, shf | {57'd0, |lost}};
      sub1_q <= a_i.sgn ^ b_i.sgn;
      tag1_q <= tag_d;
    end
  end

  // add
  logic [58:0] s2_q;
  tag_t        tag2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q   <= sub1_q ? (big1_q - sml1_q) : (big1_q + sml1_q);
      tag2_q <= tag1_q;
    end
  end

  // leading zero count
  logic [58:0] s3_q;
  logic [5:0]  lz3_q;
  logic        zero3_q;
  tag_t        tag3_q;
  logic [6:0]  lz;

  assign lz = lzc64({s2_q, 5'd0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q    <= s2_q;
      lz3_q   <= lz[5:0];
      zero3_q <= (s2_q == 59'd0);
      tag3_q  <= tag2_q;
    end
  end

  // normalize and round to double
  logic [58:0]        nrm;
  logic [53:0]        rnd;
  logic               inc_d;
  logic signed [10:0] e_d;
  logic [52:0]        m4_q;
  logic signed [10:0] e4_q;
  logic               zero4_q;
  tag_t               tag4_q;

  always_comb begin
    nrm   = s3_q << lz3_q;
    inc_d = nrm[5] && ((|nrm[4:0]) || nrm[6]);
    rnd   = {1'b0, nrm[58:6]} + {53'd0, inc_d};
    e_d   = tag3_q.exp + 11'sd1 - $signed({5'd0, lz3_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q    <= rnd[53] ? {1'b1, 52'd0} : rnd[52:0];
      e4_q    <= rnd[53] ? e_d + 11'sd1 : e_d;
      zero4_q <= zero3_q;
      tag4_q  <= tag3_q;
    end
  end

  // optional rounding to single and special values
  logic [24:0]        r24;
  logic               inc_s;
  logic signed [10:0] es;
  res_t               res_d, res_q;

  always_comb begin
    inc_s = m4_q[28] && ((|m4_q[27:0]) || m4_q[29]);
    r24   = {1'b0, m4_q[52:29]} + {24'd0, inc_s};
    es    = r24[24] ? e4_q + 11'sd1 : e4_q;
    res_d.sgn  = tag4_q.sgn;
    res_d.zero = 1'b0;
    res_d.inf  = 1'b0;
    res_d.nan  = 1'b0;
    res_d.exp  = e4_q;
    res_d.man  = m4_q;
    if (tag4_q.nan) begin
      res_d.nan = 1'b1;
    end else if (tag4_q.inf) begin
      res_d.inf = 1'b1;
      res_d.sgn = tag4_q.isg;
    end else if (zero4_q) begin
      res_d.zero = 1'b1;
    end else if (tag4_q.single) begin
      res_d.exp = es;
      res_d.man = {(r24[24] ? 24'h800000 : r24[23:0]), 29'd0};
      res_d.inf = (es > 11'sd127);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/memory_search_compare_filter_core.sv
// top level of the search candidate compare filter
//
// Takes one transfer per cycle while the output is not stalled and returns one
// verdict per transfer, in order. The verdict passes through eight register
// stages, the last being the output register. The depth is set by the float
// adder used for increased and decreased searches against a value: alignment,
// addition, leading zero count, normalization with double rounding, and single
// rounding each take one stage.
// Configuration writes are always taken and must happen while no transfer is
// in flight.
module memory_search_compare_filter_core #(
  parameter int unsigned VALUE_BITS = msfc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msfc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [63:0]                    previous_value_i,
  input  logic [63:0]                    current_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     verdict_o
);
  import msfc_pkg::*;

  localparam int unsigned Stages = SUM_LAT + 3;

  function automatic logic res_eq(input res_t r, input uf_t t);
    logic e;
    if (r.nan || t.nan) e = 1'b0;
    else if (r.zero || t.zero) e = r.zero && t.zero;
    else if (r.inf || t.inf) e = r.inf && t.inf && (r.sgn == t.sgn);
    else e = (r.sgn == t.sgn) && (r.exp == $signed({t.exp[9], t.exp}))
             && (r.man == {t.man, 29'd0});
    return e;
  endfunction

  cfg_t        cfg_q;
  logic [63:0] value_q;
  logic [Stages-1:0] vld_q;
  logic        en;

  logic [VALUE_BITS-1:0] p, c, v, pv, cv;
  uf_t         fp, fc, fv, x, y;
  logic [31:0] fpb, fcb, fvb;
  logic        single;
  dec_t        dec;
  res_t        res;
  dec_t        dpipe_q [SUM_LAT];
  verdict_e    verdict_d, verdict_q;

  assign en          = !vld_q[Stages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= CMP_EQ;
      cfg_q.fmode  <= 1'b0;
      cfg_q.useval <= 1'b0;
      value_q      <= 64'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:  cfg_q.mode   <= cmp_mode_e'(cfg_data_i[2:0]);
        REG_FLOAT: cfg_q.fmode  <= cfg_data_i[0];
        REG_USE:   cfg_q.useval <= cfg_data_i[0];
        REG_VALUE: value_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  msfc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .value_i(value_q),
    .prev_i (previous_value_i),
    .cur_i  (current_value_i),
    .p_o    (p),
    .c_o    (c),
    .v_o    (v),
    .pv_o   (pv),
    .cv_o   (cv),
    .fp_o   (fp),
    .fc_o   (fc),
    .fv_o   (fv),
    .fpb_o  (fpb),
    .fcb_o  (fcb),
    .fvb_o  (fvb)
  );

  msfc_decide #(.VALUE_BITS(VALUE_BITS)) u_decide (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .p_i     (p),
    .c_i     (c),
    .v_i     (v),
    .pv_i    (pv),
    .cv_i    (cv),
    .fp_i    (fp),
    .fc_i    (fc),
    .fv_i    (fv),
    .fpb_i   (fpb),
    .fcb_i   (fcb),
    .fvb_i   (fvb),
    .x_o     (x),
    .y_o     (y),
    .single_o(single),
    .dec_o   (dec)
  );

  msfc_sum u_sum (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (x),
    .b_i     (y),
    .single_i(single),
    .res_o   (res)
  );

  // decision travels alongside the adder
  always_ff @(posedge clk_i) begin
    if (en) begin
      dpipe_q[0] <= dec;
      for (int i = 1; i < SUM_LAT; i++) begin
        dpipe_q[i] <= dpipe_q[i-1];
      end
    end
  end

  assign verdict_d = dpipe_q[SUM_LAT-1].need ? keep(res_eq(res, dpipe_q[SUM_LAT-1].t))
                                             : dpipe_q[SUM_LAT-1].pre;

  always_ff @(posedge clk_i) begin
    if (en) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  assign verdict_o   = verdict_q;

endmodule
